### rtl/core/wet_pkg.sv
// ----------------------------------------------------------------------------
// wet_pkg
// Shared types and constants of the wakeup event tracker.
// ----------------------------------------------------------------------------
package wet_pkg;

  localparam int unsigned NUM_SOURCES_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    FN_STAY_AWAKE    = 3'd0,
    FN_RELAX         = 3'd1,
    FN_TIMED_EVENT   = 3'd2,
    FN_TICK          = 3'd3,
    FN_SAVE_COUNT    = 3'd4,
    FN_CHECK_PENDING = 3'd5,
    FN_READ_SOURCE   = 3'd6
  } func_t;

  // one queued item after classification
  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  idx;
    logic        idx_ok;
    logic [15:0] tmo;
    logic [15:0] cval;
  } cmd_t;

  // per-source row kept in RAM
  typedef struct packed {
    logic [31:0] events;
    logic [31:0] acts;
    logic [31:0] hits;
    logic [31:0] deadline;
  } row_t;

  // queue to back end handshake
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_t;

endpackage

### rtl/core/wet_in_if.sv
// ----------------------------------------------------------------------------
// wet_in_if
// Input item channel.
// ----------------------------------------------------------------------------
interface wet_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [3:0]  source_index;
  logic [15:0] timeout_ticks;
  logic [15:0] count_value;

  modport source (output valid, func, source_index, timeout_ticks, count_value,
                  input ready);
  modport sink (input valid, func, source_index, timeout_ticks, count_value,
                output ready);
endinterface

### rtl/core/wet_out_if.sv
// ----------------------------------------------------------------------------
// wet_out_if
// Result item channel.
// ----------------------------------------------------------------------------
interface wet_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] event_total;
  logic [4:0]  in_progress;
  logic        src_active;
  logic [31:0] src_event_count;
  logic [31:0] src_active_count;
  logic [31:0] src_hit_count;
  logic [4:0]  expired_count;

  modport source (output valid, ok, event_total, in_progress, src_active,
                  src_event_count, src_active_count, src_hit_count,
                  expired_count, input ready);
  modport sink (input valid, ok, event_total, in_progress, src_active,
                src_event_count, src_active_count, src_hit_count,
                expired_count, output ready);
endinterface

### rtl/core/wet_ram.sv
// ----------------------------------------------------------------------------
// wet_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/core/wet_front.sv
// ----------------------------------------------------------------------------
// wet_front
// Accepts items, checks the source index and queues them (two entries).
// ----------------------------------------------------------------------------
module wet_front #(
  parameter int unsigned NUM_SOURCES = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  wet_in_if.sink in_chan,
  output wet_pkg::q_t q,
  input  logic   q_pop
);
  import wet_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push = in_chan.valid && in_chan.ready;
  assign pop  = q_pop && (cnt_r != 2'd0);

  always_comb begin
    cmd_in.func   = in_chan.func;
    cmd_in.idx    = in_chan.source_index;
    cmd_in.idx_ok = (32'(in_chan.source_index) < 32'(NUM_SOURCES));
    cmd_in.tmo    = in_chan.timeout_ticks;
    cmd_in.cval   = in_chan.count_value;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign q.valid = (cnt_r != 2'd0);
  assign q.cmd   = mem_r[rd_ptr_r];

endmodule

### rtl/core/wet_back.sv
// ----------------------------------------------------------------------------
// wet_back
// Executes queued items: per-source update, tick expiry and hit scans,
// result register.
// ----------------------------------------------------------------------------
module wet_back #(
  parameter int unsigned NUM_SOURCES = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wet_pkg::q_t   q,
  output logic          q_pop,
  wet_out_if.source     out_chan
);
  import wet_pkg::*;

  localparam int unsigned AW  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int unsigned TW  = $clog2(NUM_SOURCES + 1);
  localparam int unsigned XW  = AW + 4;
  localparam int unsigned TXW = TW + 5;
  localparam int unsigned CXW = COUNT_BITS + 16;
  localparam int unsigned RW  = $bits(row_t);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_READ = 4'b0100,
    ST_EXEC = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [TW-1:0]         scan_r, scan_nxt;
  logic                  tick_mode_r, tick_mode_nxt;
  logic                  act_r [NUM_SOURCES];
  logic                  act_nxt [NUM_SOURCES];
  logic                  rowval_r [NUM_SOURCES];
  logic [31:0]           now_r, now_nxt;
  logic [COUNT_BITS-1:0] done_r, done_nxt;
  logic [TW-1:0]         total_r, total_nxt;
  logic [COUNT_BITS-1:0] saved_r, saved_nxt;
  logic                  chk_r, chk_nxt;
  logic [TW-1:0]         exp_r, exp_nxt;
  logic                  ok_r, ok_nxt;
  logic [AW-1:0]         rd_addr_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  row_t                  ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;
  row_t                  row_rd;

  logic                  out_valid_r, out_valid_nxt;
  logic                  o_ok_r, o_ok_nxt;
  logic [15:0]           o_tot_r, o_tot_nxt;
  logic [4:0]            o_prog_r, o_prog_nxt;
  logic                  o_act_r, o_act_nxt;
  row_t                  o_row_r, o_row_nxt;
  logic [4:0]            o_exp_r, o_exp_nxt;

  logic [XW-1:0]         idx_x;
  logic [AW-1:0]         idx_a;
  logic [AW-1:0]         cmd_a;
  logic [TW-1:0]         scan_m1;
  logic [AW-1:0]         scan_p;
  logic [CXW-1:0]        cval_x;
  logic [COUNT_BITS-1:0] cval;
  logic                  pending;
  logic                  out_free;
  row_t                  r2;
  logic                  a2;
  logic [31:0]           new_dl;
  logic [31:0]           dl_diff;
  logic [TXW-1:0]        tot_x;
  logic [CXW-1:0]        done_x;
  logic [TXW-1:0]        exp_x;

  wet_ram #(.WIDTH(RW), .DEPTH(NUM_SOURCES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign row_rd   = rowval_r[rd_addr_r] ? row_t'(ram_rdata) : '0;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    idx_x   = XW'(q.cmd.idx);
    idx_a   = idx_x[AW-1:0];
    cval_x  = CXW'(q.cmd.cval);
    cval    = cval_x[COUNT_BITS-1:0];
    scan_m1 = scan_r - TW'(1);
    scan_p  = scan_m1[AW-1:0];
  end

  always_comb begin
    logic [XW-1:0] cx;
    cx    = XW'(cmd_r.idx);
    cmd_a = cx[AW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    scan_nxt      = scan_r;
    tick_mode_nxt = tick_mode_r;
    act_nxt       = act_r;
    now_nxt       = now_r;
    done_nxt      = done_r;
    total_nxt     = total_r;
    saved_nxt     = saved_r;
    chk_nxt       = chk_r;
    exp_nxt       = exp_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    o_ok_nxt      = o_ok_r;
    o_tot_nxt     = o_tot_r;
    o_prog_nxt    = o_prog_r;
    o_act_nxt     = o_act_r;
    o_row_nxt     = o_row_r;
    o_exp_nxt     = o_exp_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = cmd_a;
    ram_wdata     = row_rd;
    ram_raddr     = cmd_a;
    pending       = 1'b0;
    r2            = row_rd;
    a2            = 1'b0;
    new_dl        = '0;
    dl_diff       = '0;
    tot_x         = '0;
    done_x        = '0;
    exp_x         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q.valid) begin
          q_pop         = 1'b1;
          cmd_nxt       = q.cmd;
          cmd_nxt.cval  = 16'(cval);
          exp_nxt       = '0;
          tick_mode_nxt = 1'b0;
          scan_nxt      = TW'(1);
          ram_raddr     = '0;
          state_nxt     = ST_READ;
          priority case (q.cmd.func)
            FN_TICK: begin
              now_nxt       = now_r + 32'd1;
              tick_mode_nxt = 1'b1;
              state_nxt     = ST_SCAN;
            end
            FN_SAVE_COUNT: begin
              if (done_r == cval && total_r == '0) begin
                saved_nxt = cval;
                chk_nxt   = 1'b1;
                ok_nxt    = 1'b1;
              end else begin
                chk_nxt   = 1'b0;
                ok_nxt    = 1'b0;
                state_nxt = ST_SCAN;
              end
            end
            FN_CHECK_PENDING: begin
              ok_nxt = 1'b0;
              if (chk_r) begin
                pending = (done_r != saved_r) || (total_r != '0);
                ok_nxt  = pending;
                chk_nxt = !pending;
                if (pending) begin
                  state_nxt = ST_SCAN;
                end
              end
            end
            default: begin
            end
          endcase
          if (state_nxt == ST_READ) begin
            ram_raddr = idx_a;
          end
        end
      end
      ST_SCAN: begin
        ram_waddr = scan_p;
        r2        = row_rd;
        if (tick_mode_r) begin
          dl_diff = now_r - row_rd.deadline;
          if (act_r[scan_p] && row_rd.deadline != '0 && !dl_diff[31]) begin
            act_nxt[scan_p] = 1'b0;
            r2.deadline     = '0;
            total_nxt       = total_r - TW'(1);
            done_nxt        = done_r + COUNT_BITS'(1);
            exp_nxt         = exp_r + TW'(1);
            ram_we          = 1'b1;
          end
        end else if (act_r[scan_p]) begin
          r2.hits = row_rd.hits + 32'd1;
          ram_we  = 1'b1;
        end
        ram_wdata = r2;
        if (32'(scan_r) < 32'(NUM_SOURCES)) begin
          ram_raddr = scan_r[AW-1:0];
          scan_nxt  = scan_r + TW'(1);
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ram_raddr = cmd_a;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          r2 = row_rd;
          a2 = act_r[cmd_a];
          if (cmd_r.idx_ok) begin
            unique case (cmd_r.func)
              FN_STAY_AWAKE: begin
                r2.events = row_rd.events + 32'd1;
                if (!a2) begin
                  a2        = 1'b1;
                  r2.acts   = row_rd.acts + 32'd1;
                  total_nxt = total_nxt + TW'(1);
                end
                r2.deadline = '0;
                ram_we      = 1'b1;
              end
              FN_RELAX: begin
                if (a2) begin
                  a2          = 1'b0;
                  r2.deadline = '0;
                  total_nxt   = total_nxt - TW'(1);
                  done_nxt    = done_nxt + COUNT_BITS'(1);
                  ram_we      = 1'b1;
                end
              end
              FN_TIMED_EVENT: begin
                r2.events = row_rd.events + 32'd1;
                if (!a2) begin
                  a2        = 1'b1;
                  r2.acts   = row_rd.acts + 32'd1;
                  total_nxt = total_nxt + TW'(1);
                end
                if (cmd_r.tmo == '0) begin
                  a2          = 1'b0;
                  r2.deadline = '0;
                  total_nxt   = total_nxt - TW'(1);
                  done_nxt    = done_nxt + COUNT_BITS'(1);
                end else begin
                  new_dl = now_r + 32'(cmd_r.tmo);
                  if (new_dl == '0) begin
                    new_dl = 32'd1;
                  end
                  dl_diff = new_dl - row_rd.deadline;
                  if (row_rd.deadline == '0 || (dl_diff != '0 && !dl_diff[31])) begin
                    r2.deadline = new_dl;
                  end
                end
                ram_we = 1'b1;
              end
              default: begin
              end
            endcase
          end
          act_nxt[cmd_a] = a2;
          ram_wdata      = r2;
          tot_x          = TXW'(total_nxt);
          done_x         = CXW'(done_nxt);
          exp_x          = TXW'(exp_r);
          out_valid_nxt  = 1'b1;
          o_ok_nxt       = (cmd_r.func == FN_SAVE_COUNT ||
                            cmd_r.func == FN_CHECK_PENDING) ? ok_r
                                                            : (total_nxt == '0);
          o_tot_nxt      = done_x[15:0];
          o_prog_nxt     = tot_x[4:0];
          o_act_nxt      = cmd_r.idx_ok ? a2 : 1'b0;
          o_row_nxt      = cmd_r.idx_ok ? r2 : '0;
          o_exp_nxt      = (cmd_r.func == FN_TICK) ? exp_x[4:0] : 5'd0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      tick_mode_r <= 1'b0;
      now_r       <= '0;
      done_r      <= '0;
      total_r     <= '0;
      saved_r     <= '0;
      chk_r       <= 1'b0;
      exp_r       <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        act_r[i]    <= 1'b0;
        rowval_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      tick_mode_r <= tick_mode_nxt;
      now_r       <= now_nxt;
      done_r      <= done_nxt;
      total_r     <= total_nxt;
      saved_r     <= saved_nxt;
      chk_r       <= chk_nxt;
      exp_r       <= exp_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
      if (ram_we) begin
        rowval_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    rd_addr_r <= ram_raddr;
    o_ok_r    <= o_ok_nxt;
    o_tot_r   <= o_tot_nxt;
    o_prog_r  <= o_prog_nxt;
    o_act_r   <= o_act_nxt;
    o_row_r   <= o_row_nxt;
    o_exp_r   <= o_exp_nxt;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.ok               = o_ok_r;
  assign out_chan.event_total      = o_tot_r;
  assign out_chan.in_progress      = o_prog_r;
  assign out_chan.src_active       = o_act_r;
  assign out_chan.src_event_count  = o_row_r.events;
  assign out_chan.src_active_count = o_row_r.acts;
  assign out_chan.src_hit_count    = o_row_r.hits;
  assign out_chan.expired_count    = o_exp_r;

endmodule

### rtl/core/wakeup_event_tracker.sv
// ----------------------------------------------------------------------------
// wakeup_event_tracker
// Wakeup source table with timed deadlines, tick expiry and pending check.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   func, source_index, timeout_ticks, count_value
//  out_chan  out  valid/ready   ok, event_total, in_progress, src_*, expired_count
//
//  Source item: ST_IDLE pops it, then ST_READ, then ST_EXEC fills the result
//  register. Tick and hit-count items first pass ST_SCAN, one source row per
//  cycle through the table RAM (separate write and read ports).
//  Two-entry input queue accepts until full while a result waits on out_chan.
//  Synchronous active-low reset; table rows read as zero until first written.
// ----------------------------------------------------------------------------
module wakeup_event_tracker #(
  parameter int unsigned NUM_SOURCES = wet_pkg::NUM_SOURCES_DEF,
  parameter int unsigned COUNT_BITS  = wet_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wet_in_if.sink     in_chan,
  wet_out_if.source  out_chan
);
  import wet_pkg::*;

  q_t   q;
  logic q_pop;

  wet_front #(.NUM_SOURCES(NUM_SOURCES)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .q      (q),
    .q_pop  (q_pop)
  );

  wet_back #(.NUM_SOURCES(NUM_SOURCES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q       (q),
    .q_pop   (q_pop),
    .out_chan(out_chan)
  );

endmodule

### test/wet_tb_if.sv
// ----------------------------------------------------------------------------
// wet_tb_if
// Testbench note: the channel interfaces come from the RTL (wet_in_if,
// wet_out_if); this file holds the shared item types and the scoreboard class of the bench.
// ----------------------------------------------------------------------------
package wet_tb_pkg;
  import wet_pkg::*;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  idx;
    logic [15:0] tmo;
    logic [15:0] cval;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] event_total;
    logic [4:0]  in_progress;
    logic        src_active;
    logic [31:0] src_event_count;
    logic [31:0] src_active_count;
    logic [31:0] src_hit_count;
    logic [4:0]  expired_count;
  } rsp_t;

  class wake_scoreboard;
    bit          act[16];
    logic [31:0] evs[16];
    logic [31:0] acts[16];
    logic [31:0] hits[16];
    logic [31:0] dl[16];
    logic [31:0] now_t;
    logic [15:0] done_cnt;
    logic [4:0]  act_tot;
    logic [15:0] saved;
    bit          chk_en;
    rsp_t        pending_rsp[$];
    int          mismatches;

    function new();
      for (int i = 0; i < 16; i++) begin
        act[i] = 0; evs[i] = 0; acts[i] = 0; hits[i] = 0; dl[i] = 0;
      end
      now_t = 0; done_cnt = 0; act_tot = 0; saved = 0; chk_en = 0;
      mismatches = 0;
    endfunction

    function void wake(int i);
      act[i] = 1; acts[i]++; act_tot++;
    endfunction

    function void sleep(int i);
      act[i] = 0; dl[i] = 0;
      if (act_tot > 0) act_tot--;
      done_cnt++;
    endfunction

    function void bump_hits();
      for (int i = 0; i < 16; i++) if (act[i]) hits[i]++;
    endfunction

    function void note_input(req_t r);
      rsp_t        e;
      logic [31:0] nd;
      logic [31:0] df;
      bit          okv;
      bit          ok_set;
      int          i;
      i = r.idx; ok_set = 0; okv = 0;
      e.expired_count = 0;
      case (r.func)
        FN_STAY_AWAKE: begin
          evs[i]++;
          if (!act[i]) wake(i);
          dl[i] = 0;
        end
        FN_RELAX: if (act[i]) sleep(i);
        FN_TIMED_EVENT: begin
          evs[i]++;
          if (!act[i]) wake(i);
          if (r.tmo == 0) sleep(i);
          else begin
            nd = now_t + r.tmo;
            if (nd == 0) nd = 1;
            df = nd - dl[i];
            if (dl[i] == 0 || (df != 0 && !df[31])) dl[i] = nd;
          end
        end
        FN_TICK: begin
          now_t++;
          for (int k = 0; k < 16; k++) begin
            df = now_t - dl[k];
            if (act[k] && dl[k] != 0 && !df[31]) begin
              sleep(k);
              e.expired_count++;
            end
          end
        end
        FN_SAVE_COUNT: begin
          chk_en = 0;
          if (done_cnt == r.cval && act_tot == 0) begin
            saved = r.cval; chk_en = 1;
          end else bump_hits();
          okv = chk_en; ok_set = 1;
        end
        FN_CHECK_PENDING: begin
          okv = 0;
          if (chk_en) begin
            okv = (done_cnt != saved) || act_tot > 0;
            chk_en = !okv;
            if (okv) bump_hits();
          end
          ok_set = 1;
        end
        default: ;
      endcase
      e.ok = ok_set ? okv : (act_tot == 0);
      e.event_total = done_cnt;
      e.in_progress = act_tot;
      e.src_active = act[i];
      e.src_event_count = evs[i];
      e.src_active_count = acts[i];
      e.src_hit_count = hits[i];
      pending_rsp.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item");
        return;
      end
      e = pending_rsp.pop_front();
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp ok=%0d tot=%0d prog=%0d act=%0d ev=%0d ac=%0d hit=%0d exp=%0d",
            e.ok, e.event_total, e.in_progress, e.src_active, e.src_event_count,
            e.src_active_count, e.src_hit_count, e.expired_count);
          $display("          act ok=%0d tot=%0d prog=%0d act=%0d ev=%0d ac=%0d hit=%0d exp=%0d",
            a.ok, a.event_total, a.in_progress, a.src_active, a.src_event_count,
            a.src_active_count, a.src_hit_count, a.expired_count);
        end
      end
    endfunction
  endclass
endpackage

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives stay/relax/timed/tick/save/check/read items into the wakeup event
// tracker with bursty input and random output stalls; a scoreboard predicts
// every result item and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import wet_pkg::*;
  import wet_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  always #2 clk = ~clk;

  wet_in_if  in_chan();
  wet_out_if out_chan();

  wakeup_event_tracker i_dut (.clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink),
    .out_chan(out_chan.source));

  wake_scoreboard sb = new();
  int idle_cycles = 0;
  bit timed_out = 0;
  int stall_mode = 0;

  initial begin
    in_chan.valid = 0; in_chan.func = 0; in_chan.source_index = 0;
    in_chan.timeout_ticks = 0; in_chan.count_value = 0;
    out_chan.ready = 0;
  end

  always @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      sb.note_input('{in_chan.func, in_chan.source_index, in_chan.timeout_ticks,
        in_chan.count_value});
    end
    if (out_chan.valid && out_chan.ready)
      sb.check_result('{out_chan.ok, out_chan.event_total, out_chan.in_progress,
        out_chan.src_active, out_chan.src_event_count, out_chan.src_active_count,
        out_chan.src_hit_count, out_chan.expired_count});
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || !rst_n)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("testbench: FAIL");
      $finish;
    end
    case (stall_mode)
      0: out_chan.ready <= 1;
      1: out_chan.ready <= ($urandom_range(0, 3) != 0);
      default: out_chan.ready <= ($urandom_range(0, 3) == 0);
    endcase
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send_item(logic [2:0] f, logic [3:0] s, logic [15:0] t,
                           logic [15:0] c);
    in_chan.valid <= 1; in_chan.func <= f; in_chan.source_index <= s;
    in_chan.timeout_ticks <= t; in_chan.count_value <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic pause(int n);
    in_chan.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 0;
    @(posedge clk);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic rand_item();
    int r;
    logic [2:0]  f;
    logic [15:0] t;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 18) f = FN_STAY_AWAKE;
    else if (r < 33) f = FN_RELAX;
    else if (r < 53) f = FN_TIMED_EVENT;
    else if (r < 73) f = FN_TICK;
    else if (r < 81) f = FN_SAVE_COUNT;
    else if (r < 89) f = FN_CHECK_PENDING;
    else if (r < 97) f = FN_READ_SOURCE;
    else f = 3'd7;
    case ($urandom_range(0, 4))
      0: t = 0;
      1, 2: t = $urandom_range(1, 8);
      3: t = $urandom_range(0, 65535);
      default: t = 16'hFFFF - $urandom_range(0, 3);
    endcase
    c = ($urandom_range(0, 2) != 0) ? sb.done_cnt : 16'($urandom);
    send_item(f, 4'($urandom), t, c);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_item(FN_READ_SOURCE, 0, 0, 0);
    send_item(FN_SAVE_COUNT, 0, 0, 0);
    send_item(FN_CHECK_PENDING, 0, 0, 0);
    send_item(FN_SAVE_COUNT, 0, 0, 16'hFFFF);
    send_item(FN_STAY_AWAKE, 0, 16'hFFFF, 16'hFFFF);
    send_item(FN_TIMED_EVENT, 15, 0, 0);
    send_item(FN_TIMED_EVENT, 15, 16'hFFFF, 0);
    send_item(FN_TIMED_EVENT, 15, 1, 0);
    send_item(FN_TIMED_EVENT, 3, 2, 0);
    send_item(FN_TICK, 9, 0, 0);
    send_item(FN_TICK, 9, 0, 0);
    send_item(FN_CHECK_PENDING, 0, 0, 0);
    send_item(FN_SAVE_COUNT, 0, 0, 0);
    send_item(FN_RELAX, 0, 0, 0);
    send_item(FN_RELAX, 0, 0, 0);
    send_item(FN_SAVE_COUNT, 15, 0, sb.done_cnt);
    send_item(FN_CHECK_PENDING, 15, 0, 0);
    send_item(FN_STAY_AWAKE, 7, 0, 0);
    send_item(FN_CHECK_PENDING, 7, 0, 0);
    send_item(3'd7, 7, 16'hAAAA, 16'h5555);
    send_item(FN_RELAX, 7, 16'h5555, 16'hAAAA);
    send_item(FN_TIMED_EVENT, 15, 1, 0);
    drain();
    for (int n = 0; n < 1350;) begin
      int b;
      b = $urandom_range(1, 30);
      for (int k = 0; k < b; k++) begin
        rand_item();
        n++;
      end
      if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 25));
      if ($urandom_range(0, 40) == 0) drain();
    end
    drain();
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule

### sim.f
rtl/core/wet_pkg.sv
rtl/core/wet_in_if.sv
rtl/core/wet_out_if.sv
rtl/core/wet_ram.sv
rtl/core/wet_front.sv
rtl/core/wet_back.sv
rtl/core/wakeup_event_tracker.sv
test/wet_tb_if.sv
test/testbench.sv
